>>> hdl/fcmc_pkg.sv
// shared types and constants of the fifo cache miss counter
`timescale 1ns / 1ps

package fcmc_pkg;

    // miss counter and result beat layout
    localparam int MISS_W     = 32;
    localparam int CAP_W      = 8;
    localparam int OUT_DATA_W = 40;
    localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

    // per-cycle commands broadcast along the cell row
    typedef struct packed {
        logic shift;
        logic compare;
    } t_cell_ctl;

endpackage

>>> hdl/fifo_cache_miss_counter.sv
// fully associative key store with fifo replacement and a saturating miss counter
//
// keys arrive on the s_axis channel, one key per beat in tdata. each key is
// compared against every valid entry; a hit leaves the store unchanged, a miss
// bumps the miss counter and inserts the key as the newest entry, dropping the
// oldest once the fill reaches the capacity register. results leave on m_axis:
// tdata bit 0 is the hit flag, bits 32:1 the running miss count.
// capacity is written on the cfg channel (always ready); the user must write it
// only while the block is idle, which the block itself does not enforce;
// values above ENTRIES act as ENTRIES, zero makes every key a miss. entries
// live in a row of cells that shift by one on every insert. an item steps
// through accept, compare in all cells, grouped or of the match bits, update;
// the next key is taken the cycle after the update, so a key is not accepted
// while the previous one is still being compared or updated.
// a finished result waits in the output register; the next key is accepted
// meanwhile, and its update holds until m_axis takes the waiting beat.
// reset empties the store, clears the miss count and sets capacity to 128.
`timescale 1ns / 1ps

module fifo_cache_miss_counter #(
    parameter int ENTRIES  = 128,
    parameter int KEY_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // s_axis tdata: word_key
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [((KEY_BITS+7)/8)*8-1:0]          i_s_axis_tdata,
    // m_axis tdata: hit, miss_count, zero fill
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic [fcmc_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata,
    // cfg: capacity
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [fcmc_pkg::CAP_W-1:0]             i_cfg_data
);

    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (FILL_W > fcmc_pkg::CAP_W) ? FILL_W : fcmc_pkg::CAP_W;
    localparam int GRP    = 16;
    localparam int NGRP   = (ENTRIES + GRP - 1) / GRP;
    localparam int MW     = fcmc_pkg::MISS_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_RED  = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [fcmc_pkg::CAP_W-1:0]  r_cap;
    logic [KEY_BITS-1:0]         r_key;
    logic [FILL_W-1:0]           r_fill, n_fill;
    logic [MW-1:0]               r_misses, n_misses;
    logic [NGRP-1:0]             r_grp;
    logic                        r_out_valid;
    logic                        r_out_hit;
    logic [MW-1:0]               r_out_miss;

    fcmc_pkg::t_cell_ctl         w_ctl;
    logic [KEY_BITS-1:0]         w_keys [ENTRIES];
    logic [ENTRIES-1:0]          w_valid;
    logic [ENTRIES-1:0]          w_match;
    logic [NGRP*GRP-1:0]         w_match_pad;

    logic [CMP_W-1:0]            w_cap_ext, w_cap_eff, w_fill_ext;
    logic                        w_cap_nz, w_hit, w_insert, w_out_free, w_upd_fire;

    // capacity register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= fcmc_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    assign w_cap_ext  = CMP_W'(r_cap);
    assign w_cap_eff  = (w_cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : w_cap_ext;
    assign w_cap_nz   = (r_cap != '0);
    assign w_fill_ext = CMP_W'(r_fill);

    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_upd_fire = (r_state == ST_UPD) && w_out_free;
    assign w_hit      = w_cap_nz && (|r_grp);
    assign w_insert   = w_upd_fire && !w_hit && w_cap_nz;

    assign o_s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        w_ctl.shift   = w_insert;
        w_ctl.compare = (r_state == ST_CMP);
    end

    // fill holds when full or when capacity was lowered below it
    always_comb begin
        n_fill = r_fill;
        if (w_fill_ext < w_cap_eff) begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    always_comb begin
        n_misses = r_misses;
        if (r_misses != {MW{1'b1}}) begin
            n_misses = r_misses + MW'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP:  n_state = ST_RED;
            ST_RED:  n_state = ST_UPD;
            ST_UPD: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_insert) begin
                r_fill <= n_fill;
            end
            if (w_upd_fire && !w_hit) begin
                r_misses <= n_misses;
            end
            if (w_upd_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_key <= i_s_axis_tdata[KEY_BITS-1:0];
        end
        if (w_upd_fire) begin
            r_out_hit  <= w_hit;
            r_out_miss <= w_hit ? r_misses : n_misses;
        end
    end

    // group or of the registered match bits
    always_comb begin
        w_match_pad = '0;
        w_match_pad[ENTRIES-1:0] = w_match;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RED) begin
            for (int g = 0; g < NGRP; g++) begin
                r_grp[g] <= |w_match_pad[g*GRP +: GRP];
            end
        end
    end

    // cell row, newest entry in cell 0
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        fcmc_cell #(
            .KEY_BITS (KEY_BITS),
            .FILL_W   (FILL_W),
            .INDEX    (i)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_key       (r_key),
            .i_prev_key  ((i == 0) ? r_key : w_keys[(i == 0) ? 0 : i-1]),
            .i_fill_next (n_fill),
            .o_key       (w_keys[i]),
            .o_valid     (w_valid[i]),
            .o_match     (w_match[i])
        );
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(fcmc_pkg::OUT_DATA_W - MW - 1)'(0), r_out_miss, r_out_hit};

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(ENTRIES))
        else $error("fill count beyond entry count");

    a_shift_in_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.shift |-> (r_state == ST_UPD) && !w_hit)
        else $error("cell row shifted outside a miss update");

    a_newest_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_insert |=> w_valid[0] && (w_keys[0] == $past(r_key)))
        else $error("inserted key not held as newest entry");

    a_miss_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_UPD) |=> $stable(r_misses))
        else $error("miss count moved outside an update");
`endif

endmodule

>>> hdl/fcmc_cell.sv
// one entry of the key row: holds a key, its valid flag and a registered match
`timescale 1ns / 1ps

module fcmc_cell #(
    parameter int KEY_BITS = 16,
    parameter int FILL_W   = 8,
    parameter int INDEX    = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fcmc_pkg::t_cell_ctl   i_ctl,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [KEY_BITS-1:0]   i_prev_key,
    input  logic [FILL_W-1:0]     i_fill_next,
    output logic [KEY_BITS-1:0]   o_key,
    output logic                  o_valid,
    output logic                  o_match
);

    logic [KEY_BITS-1:0] r_key;
    logic                r_valid;
    logic                r_match;

    // key moves one cell toward the old end on every insert
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key <= i_prev_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            // cells past the fill drop out, which removes the oldest entry
            if (i_ctl.shift) begin
                r_valid <= (FILL_W'(INDEX) < i_fill_next);
            end
            if (i_ctl.compare) begin
                r_match <= r_valid && (r_key == i_key);
            end
        end
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;
    assign o_match = r_match;

endmodule
